[rtl/quaternion_slerp_core_assert.svh]
// Assertion macros for the quaternion slerp core.
// Included by rtl files that check their own pipeline; no other dependencies.
`ifndef QUATERNION_SLERP_CORE_ASSERT_SVH
`define QUATERNION_SLERP_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define QSC_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("quaternion_slerp_core: check failed");

// next-cycle implication, disabled while reset is asserted
`define QSC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("quaternion_slerp_core: check failed");

`endif

[rtl/qslerp_pkg.sv]
// Shared constants, types and the CORDIC angle table of the quaternion slerp core.
// No dependencies.
package qslerp_pkg;

  localparam int CompFracBits = 14;
  localparam int Q30Bits      = 30;
  localparam int CordicSteps  = 30;
  localparam int ArctanLen    = 10;
  localparam int MagShl       = Q30Bits - 2 * CompFracBits;
  localparam int FracShl      = Q30Bits - CompFracBits;

  localparam logic [30:0] One30 = 31'd1 << Q30Bits;
  localparam logic [14:0] OneFrac = 15'd1 << CompFracBits;
  localparam logic signed [32:0] CordicInvGain = 33'sd652032874;

  localparam logic signed [31:0] ArctanQ30 [ArctanLen] = '{
    32'sd843314857, 32'sd497837829, 32'sd263043837, 32'sd133525159, 32'sd67021687,
    32'sd33543516, 32'sd16775851, 32'sd8388437, 32'sd4194283, 32'sd2097149
  };

  typedef logic signed [15:0] comp_t;
  typedef logic signed [16:0] compn_t;

  typedef struct packed {
    comp_t  [3:0] a;
    compn_t [3:0] b;
    logic   [14:0] frac;
  } pair_t;

  typedef struct packed {
    pair_t       pair;
    logic [30:0] mag;
  } rad_side_t;

  typedef struct packed {
    pair_t pair;
    logic  lin;
  } wgt_side_t;

  typedef struct packed {
    logic [3:0][30:0] am;
    logic [3:0]       neg;
    logic             zero;
  } nrm_side_t;

  typedef struct packed {
    logic [3:0] neg;
    logic       zero;
  } out_side_t;

  function automatic logic signed [31:0] step_angle(input int i);
    logic signed [31:0] r;
    if (i < ArctanLen) r = ArctanQ30[i];
    else r = 32'sd1 <<< (Q30Bits - i);
    return r;
  endfunction

endpackage

[rtl/qslerp_sqrt.sv]
// Pipelined floor square root, one result bit per register stage.
// Carries a sideband payload alongside; no package dependencies.
module qslerp_sqrt #(
  parameter int InW   = 62,
  parameter int SideW = 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               vld_i,
  input  logic [InW-1:0]     rad_i,
  input  logic [SideW-1:0]   side_i,
  output logic               vld_o,
  output logic [InW/2-1:0]   root_o,
  output logic [SideW-1:0]   side_o
);

  localparam int N    = InW / 2;
  localparam int RemW = N + 2;

  logic             vld_q  [N];
  logic [InW-1:0]   val_q  [N];
  logic [RemW-1:0]  rem_q  [N];
  logic [N-1:0]     root_q [N];
  logic [SideW-1:0] side_q [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic             s_vld;
    logic [InW-1:0]   s_val;
    logic [RemW-1:0]  s_rem;
    logic [N-1:0]     s_root;
    logic [SideW-1:0] s_side;
    logic [RemW-1:0]  rem_t, trial, rem_d;
    logic [N-1:0]     root_d;

    if (k == 0) begin : g_first
      assign s_vld  = vld_i;
      assign s_val  = rad_i;
      assign s_rem  = '0;
      assign s_root = '0;
      assign s_side = side_i;
    end else begin : g_next
      assign s_vld  = vld_q[k-1];
      assign s_val  = val_q[k-1];
      assign s_rem  = rem_q[k-1];
      assign s_root = root_q[k-1];
      assign s_side = side_q[k-1];
    end

    always_comb begin
      rem_t = {s_rem[RemW-3:0], s_val[InW-1 -: 2]};
      trial = {s_root, 2'b01};
      if (rem_t >= trial) begin
        rem_d  = rem_t - trial;
        root_d = {s_root[N-2:0], 1'b1};
      end else begin
        rem_d  = rem_t;
        root_d = {s_root[N-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vld_q[k] <= 1'b0;
      else if (en_i) vld_q[k] <= s_vld;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        val_q[k]  <= {s_val[InW-3:0], 2'b00};
        rem_q[k]  <= rem_d;
        root_q[k] <= root_d;
        side_q[k] <= s_side;
      end
    end
  end

  assign vld_o  = vld_q[N-1];
  assign root_o = root_q[N-1];
  assign side_o = side_q[N-1];

endmodule

[rtl/qslerp_div.sv]
// Pipelined restoring divider, one quotient bit per stage, lanes share one divisor.
// Flags quotients that do not fit QuoW bits; no package dependencies.
module qslerp_div #(
  parameter int NumW  = 61,
  parameter int DenW  = 31,
  parameter int QuoW  = 31,
  parameter int Lanes = 2,
  parameter int SideW = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        vld_i,
  input  logic [Lanes-1:0][NumW-1:0]  num_i,
  input  logic [DenW-1:0]             den_i,
  input  logic [SideW-1:0]            side_i,
  output logic                        vld_o,
  output logic [Lanes-1:0][QuoW-1:0]  quo_o,
  output logic [Lanes-1:0]            ovf_o,
  output logic [SideW-1:0]            side_o
);

  localparam int CmpW = ((NumW > DenW + QuoW) ? NumW : DenW + QuoW) + 1;

  logic                       vld_q  [QuoW];
  logic [DenW-1:0]            den_q  [QuoW];
  logic [Lanes-1:0][NumW-1:0] rem_q  [QuoW];
  logic [Lanes-1:0][QuoW-1:0] quo_q  [QuoW];
  logic [Lanes-1:0]           ovf_q  [QuoW];
  logic [SideW-1:0]           side_q [QuoW];

  for (genvar k = 0; k < QuoW; k++) begin : g_stage
    localparam int Bit = QuoW - 1 - k;
    logic                       s_vld;
    logic [DenW-1:0]            s_den;
    logic [Lanes-1:0][NumW-1:0] s_rem, rem_d;
    logic [Lanes-1:0][QuoW-1:0] s_quo, quo_d;
    logic [Lanes-1:0]           s_ovf, ovf_d;
    logic [SideW-1:0]           s_side;

    if (k == 0) begin : g_first
      assign s_vld  = vld_i;
      assign s_den  = den_i;
      assign s_rem  = num_i;
      assign s_quo  = '0;
      assign s_ovf  = '0;
      assign s_side = side_i;
    end else begin : g_next
      assign s_vld  = vld_q[k-1];
      assign s_den  = den_q[k-1];
      assign s_rem  = rem_q[k-1];
      assign s_quo  = quo_q[k-1];
      assign s_ovf  = ovf_q[k-1];
      assign s_side = side_q[k-1];
    end

    always_comb begin : p_step
      logic [CmpW-1:0] remx, dsh, dtop;
      dsh  = CmpW'(s_den) << Bit;
      dtop = CmpW'(s_den) << QuoW;
      rem_d = s_rem;
      quo_d = s_quo;
      ovf_d = s_ovf;
      for (int l = 0; l < Lanes; l++) begin
        remx = CmpW'(s_rem[l]);
        if (remx >= dsh) begin
          rem_d[l]      = NumW'(remx - dsh);
          quo_d[l][Bit] = 1'b1;
        end
        if (k == 0) ovf_d[l] = (remx >= dtop);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vld_q[k] <= 1'b0;
      else if (en_i) vld_q[k] <= s_vld;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[k]  <= s_den;
        rem_q[k]  <= rem_d;
        quo_q[k]  <= quo_d;
        ovf_q[k]  <= ovf_d;
        side_q[k] <= s_side;
      end
    end
  end

  assign vld_o  = vld_q[QuoW-1];
  assign quo_o  = quo_q[QuoW-1];
  assign ovf_o  = ovf_q[QuoW-1];
  assign side_o = side_q[QuoW-1];

endmodule

[rtl/quaternion_slerp_core.sv]
// Quaternion slerp core: dot, sin(theta) root, CORDIC angle and sines, weights,
// blend and renormalization, all in one stalling pipeline. Uses qslerp_pkg,
// qslerp_sqrt, qslerp_div and quaternion_slerp_core_assert.svh.
//
//   port group | dir | contents (tdata from bit 0 up)
//   s_axis     | in  | a_w a_x a_y a_z b_w b_x b_y b_z fraction, zero pad to 144
//   m_axis     | out | out_w out_x out_y out_z
//
// One beat per cycle in and out unless the output stalls; a beat accepted on s_axis passes
// through 187 register stages to m_axis, set by the two square roots
// (31, 32), the two CORDIC chains (30 each), the two dividers (31, 15) and 18 single steps.
// Reset clears only the valid bits. When the output beat is held, the whole
// pipeline holds and s_axis_tready drops in the same cycle.
`include "quaternion_slerp_core_assert.svh"
module quaternion_slerp_core
  import qslerp_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [143:0] s_axis_tdata,   // a_w a_x a_y a_z b_w b_x b_y b_z fraction
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata    // out_w out_x out_y out_z
);

  logic adv;

  // input and product stages
  logic in_vld_q, pr_vld_q, dt_vld_q, rd_vld_q;
  pair_t in_pair_q, pr_pair_q, dt_pair_q, rd_pair_q;
  logic signed [31:0] prod_q [4];
  logic [30:0] dt_mag_q, rd_mag_q;
  logic [61:0] rad_q;

  // sin(theta) root
  logic        sq1_vld;
  logic [30:0] sq1_root;
  rad_side_t   sq1_side;

  // atan2 chain
  logic               at_vld_q  [CordicSteps];
  logic signed [32:0] at_x_q    [CordicSteps];
  logic signed [32:0] at_y_q    [CordicSteps];
  logic signed [31:0] at_z_q    [CordicSteps];
  pair_t              at_pair_q [CordicSteps];
  logic [30:0]        at_s30_q  [CordicSteps];

  // angle split
  logic        th_vld_q, ag_vld_q;
  pair_t       th_pair_q, ag_pair_q;
  logic [30:0] th_s30_q, ag_s30_q, th_theta_q;
  logic [45:0] th_mul_q;
  logic signed [31:0] ag_ang_q [2];

  // sine chain
  logic               sn_vld_q  [CordicSteps];
  logic signed [32:0] sn_x_q    [CordicSteps][2];
  logic signed [32:0] sn_y_q    [CordicSteps][2];
  logic signed [31:0] sn_z_q    [CordicSteps][2];
  pair_t              sn_pair_q [CordicSteps];
  logic [30:0]        sn_s30_q  [CordicSteps];

  logic        sv_vld_q;
  logic [1:0][30:0] sv_sine_q;
  logic [30:0] sv_s30_q;
  wgt_side_t   sv_side_q;
  logic [1:0][60:0] wd_num;

  logic             wd_vld;
  logic [1:0][30:0] wd_quo;
  logic [1:0]       wd_ovf;
  wgt_side_t        wd_side;

  // weights and blend
  logic        wt_vld_q, bp_vld_q, bs_vld_q, ab_vld_q, mx_vld_q, sh_vld_q, rs_vld_q;
  logic        sq_vld_q, ss_vld_q;
  pair_t       wt_pair_q;
  logic [30:0] wt_wa_q, wt_wb_q;
  logic signed [47:0] bp_pa_q [4];
  logic signed [47:0] bp_pb_q [4];
  logic signed [47:0] bs_r_q [4];
  logic signed [47:0] ab_r_q [4];
  logic signed [47:0] mx_r_q [4];
  logic signed [47:0] sh_r_q [4];
  logic [3:0][46:0] ab_am_q;
  logic [46:0] mx_m_q;
  logic [4:0]  sh_sh_q;
  logic        sh_zero_q, rs_zero_q, sq_zero_q, ss_zero_q;
  logic signed [30:0] rs_r_q [4];
  logic [61:0] sq_sq_q [4];
  logic [3:0][30:0] sq_am_q;
  logic [3:0]  sq_neg_q;
  logic [63:0] ss_sum_q;
  nrm_side_t   ss_side;

  logic        sq2_vld;
  logic [31:0] sq2_root;
  nrm_side_t   sq2_side;

  logic        nd_vld_q;
  logic [3:0][44:0] nd_num_q;
  logic [31:0] nd_den_q;
  out_side_t   nd_side_q;

  logic             od_vld;
  logic [3:0][14:0] od_quo;
  logic [3:0]       od_ovf;
  out_side_t        od_side;

  logic        out_vld_q;
  logic signed [15:0] out_q [4];

  assign adv           = !out_vld_q || m_axis_tready;
  assign s_axis_tready = adv;

  // valid bits of the inline stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      pr_vld_q  <= 1'b0;
      dt_vld_q  <= 1'b0;
      rd_vld_q  <= 1'b0;
      th_vld_q  <= 1'b0;
      ag_vld_q  <= 1'b0;
      sv_vld_q  <= 1'b0;
      wt_vld_q  <= 1'b0;
      bp_vld_q  <= 1'b0;
      bs_vld_q  <= 1'b0;
      ab_vld_q  <= 1'b0;
      mx_vld_q  <= 1'b0;
      sh_vld_q  <= 1'b0;
      rs_vld_q  <= 1'b0;
      sq_vld_q  <= 1'b0;
      ss_vld_q  <= 1'b0;
      nd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      in_vld_q  <= s_axis_tvalid;
      pr_vld_q  <= in_vld_q;
      dt_vld_q  <= pr_vld_q;
      rd_vld_q  <= dt_vld_q;
      th_vld_q  <= at_vld_q[CordicSteps-1];
      ag_vld_q  <= th_vld_q;
      sv_vld_q  <= sn_vld_q[CordicSteps-1];
      wt_vld_q  <= wd_vld;
      bp_vld_q  <= wt_vld_q;
      bs_vld_q  <= bp_vld_q;
      ab_vld_q  <= bs_vld_q;
      mx_vld_q  <= ab_vld_q;
      sh_vld_q  <= mx_vld_q;
      rs_vld_q  <= sh_vld_q;
      sq_vld_q  <= rs_vld_q;
      ss_vld_q  <= sq_vld_q;
      nd_vld_q  <= sq2_vld;
      out_vld_q <= od_vld;
    end
  end

  // input beat, dot product, |dot| in Q30, radicand of sin(theta)
  always_ff @(posedge clk_i) begin : p_front
    logic signed [33:0] dot;
    logic [33:0]        absd;
    logic [14:0]        frac;
    logic [61:0]        msq;
    pair_t              pn;
    if (adv) begin
      for (int c = 0; c < 4; c++) begin
        in_pair_q.a[c] <= s_axis_tdata[16*c +: 16];
        in_pair_q.b[c] <= 17'($signed(s_axis_tdata[64 + 16*c +: 16]));
      end
      frac = s_axis_tdata[142:128];
      in_pair_q.frac <= (frac > OneFrac) ? OneFrac : frac;

      for (int c = 0; c < 4; c++)
        prod_q[c] <= $signed(in_pair_q.a[c]) * $signed(in_pair_q.b[c][15:0]);
      pr_pair_q <= in_pair_q;

      dot = 34'(prod_q[0]) + 34'(prod_q[1]) + 34'(prod_q[2]) + 34'(prod_q[3]);
      pn  = pr_pair_q;
      if (dot < 0) begin
        for (int c = 0; c < 4; c++)
          pn.b[c] = -$signed(pr_pair_q.b[c]);
        absd = 34'(-dot);
      end else begin
        absd = 34'(dot);
      end
      dt_pair_q <= pn;
      if (absd > 34'(One30 >> MagShl)) dt_mag_q <= One30;
      else dt_mag_q <= 31'(absd << MagShl);

      msq = 62'(dt_mag_q) * 62'(dt_mag_q);
      rad_q     <= (62'd1 << 60) - msq;
      rd_mag_q  <= dt_mag_q;
      rd_pair_q <= dt_pair_q;
    end
  end

  qslerp_sqrt #(
    .InW   (62),
    .SideW ($bits(rad_side_t))
  ) u_sqrt_sin (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (rd_vld_q),
    .rad_i  (rad_q),
    .side_i ({rd_pair_q, rd_mag_q}),
    .vld_o  (sq1_vld),
    .root_o (sq1_root),
    .side_o (sq1_side)
  );

  // theta = atan2(sin, cos) by vectoring
  for (genvar k = 0; k < CordicSteps; k++) begin : g_atan
    logic               s_vld;
    logic signed [32:0] s_x, s_y, xs, ys;
    logic signed [31:0] s_z;
    pair_t              s_pair;
    logic [30:0]        s_s30;

    if (k == 0) begin : g_first
      assign s_vld  = sq1_vld;
      assign s_x    = 33'(sq1_side.mag);
      assign s_y    = 33'(sq1_root);
      assign s_z    = '0;
      assign s_pair = sq1_side.pair;
      assign s_s30  = sq1_root;
    end else begin : g_next
      assign s_vld  = at_vld_q[k-1];
      assign s_x    = at_x_q[k-1];
      assign s_y    = at_y_q[k-1];
      assign s_z    = at_z_q[k-1];
      assign s_pair = at_pair_q[k-1];
      assign s_s30  = at_s30_q[k-1];
    end

    assign xs = s_x >>> k;
    assign ys = s_y >>> k;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) at_vld_q[k] <= 1'b0;
      else if (adv) at_vld_q[k] <= s_vld;
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (s_y > 0) begin
          at_x_q[k] <= s_x + ys;
          at_y_q[k] <= s_y - xs;
          at_z_q[k] <= s_z + step_angle(k);
        end else begin
          at_x_q[k] <= s_x - ys;
          at_y_q[k] <= s_y + xs;
          at_z_q[k] <= s_z - step_angle(k);
        end
        at_pair_q[k] <= s_pair;
        at_s30_q[k]  <= s_s30;
      end
    end
  end

  // split theta into (1-f) theta and f theta
  always_ff @(posedge clk_i) begin : p_angle
    logic signed [31:0] zl;
    logic [30:0]        theta;
    logic [31:0]        angb;
    if (adv) begin
      zl    = at_z_q[CordicSteps-1];
      theta = zl[31] ? '0 : zl[30:0];
      th_theta_q <= theta;
      th_mul_q   <= 46'(at_pair_q[CordicSteps-1].frac) * 46'(theta);
      th_pair_q  <= at_pair_q[CordicSteps-1];
      th_s30_q   <= at_s30_q[CordicSteps-1];

      angb = 32'(th_mul_q >> CompFracBits);
      ag_ang_q[1] <= $signed(angb);
      ag_ang_q[0] <= $signed(32'(th_theta_q) - angb);
      ag_pair_q   <= th_pair_q;
      ag_s30_q    <= th_s30_q;
    end
  end

  // sin of both angles by rotation
  for (genvar k = 0; k < CordicSteps; k++) begin : g_sin
    logic               s_vld;
    logic signed [32:0] s_x [2];
    logic signed [32:0] s_y [2];
    logic signed [31:0] s_z [2];
    pair_t              s_pair;
    logic [30:0]        s_s30;

    if (k == 0) begin : g_first
      assign s_vld  = ag_vld_q;
      assign s_x[0] = CordicInvGain;
      assign s_x[1] = CordicInvGain;
      assign s_y[0] = '0;
      assign s_y[1] = '0;
      assign s_z[0] = ag_ang_q[0];
      assign s_z[1] = ag_ang_q[1];
      assign s_pair = ag_pair_q;
      assign s_s30  = ag_s30_q;
    end else begin : g_next
      assign s_vld  = sn_vld_q[k-1];
      assign s_x[0] = sn_x_q[k-1][0];
      assign s_x[1] = sn_x_q[k-1][1];
      assign s_y[0] = sn_y_q[k-1][0];
      assign s_y[1] = sn_y_q[k-1][1];
      assign s_z[0] = sn_z_q[k-1][0];
      assign s_z[1] = sn_z_q[k-1][1];
      assign s_pair = sn_pair_q[k-1];
      assign s_s30  = sn_s30_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sn_vld_q[k] <= 1'b0;
      else if (adv) sn_vld_q[k] <= s_vld;
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        for (int l = 0; l < 2; l++) begin
          if (s_z[l] >= 0) begin
            sn_x_q[k][l] <= s_x[l] - (s_y[l] >>> k);
            sn_y_q[k][l] <= s_y[l] + (s_x[l] >>> k);
            sn_z_q[k][l] <= s_z[l] - step_angle(k);
          end else begin
            sn_x_q[k][l] <= s_x[l] + (s_y[l] >>> k);
            sn_y_q[k][l] <= s_y[l] - (s_x[l] >>> k);
            sn_z_q[k][l] <= s_z[l] + step_angle(k);
          end
        end
        sn_pair_q[k] <= s_pair;
        sn_s30_q[k]  <= s_s30;
      end
    end
  end

  // clamp sines, flag the linear fallback
  always_ff @(posedge clk_i) begin : p_sine
    logic signed [32:0] y;
    if (adv) begin
      for (int l = 0; l < 2; l++) begin
        y = sn_y_q[CordicSteps-1][l];
        if (y < 0) sv_sine_q[l] <= '0;
        else if (y > $signed(33'(One30))) sv_sine_q[l] <= One30;
        else sv_sine_q[l] <= y[30:0];
      end
      sv_s30_q       <= sn_s30_q[CordicSteps-1];
      sv_side_q.pair <= sn_pair_q[CordicSteps-1];
      sv_side_q.lin  <= (sn_s30_q[CordicSteps-1] <= 31'd1);
    end
  end

  assign wd_num[0] = {sv_sine_q[0], 30'd0};
  assign wd_num[1] = {sv_sine_q[1], 30'd0};

  qslerp_div #(
    .NumW  (61),
    .DenW  (31),
    .QuoW  (31),
    .Lanes (2),
    .SideW ($bits(wgt_side_t))
  ) u_div_wgt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (sv_vld_q),
    .num_i  (wd_num),
    .den_i  (sv_s30_q),
    .side_i (sv_side_q),
    .vld_o  (wd_vld),
    .quo_o  (wd_quo),
    .ovf_o  (wd_ovf),
    .side_o (wd_side)
  );

  // weights, blend, max magnitude, shift, squares and their sum
  always_ff @(posedge clk_i) begin : p_blend
    logic [30:0]        f30;
    logic [46:0]        m01, m23;
    logic [16:0]        top;
    logic [4:0]         sh;
    logic signed [47:0] r;
    logic [63:0]        sum;
    if (adv) begin
      f30 = 31'(wd_side.pair.frac) << FracShl;
      if (wd_side.lin) begin
        wt_wa_q <= One30 - f30;
        wt_wb_q <= f30;
      end else begin
        wt_wa_q <= (wd_ovf[0] || wd_quo[0] > One30) ? One30 : wd_quo[0];
        wt_wb_q <= (wd_ovf[1] || wd_quo[1] > One30) ? One30 : wd_quo[1];
      end
      wt_pair_q <= wd_side.pair;

      for (int c = 0; c < 4; c++) begin
        bp_pa_q[c] <= $signed(48'({1'b0, wt_wa_q})) * 48'(wt_pair_q.a[c]);
        bp_pb_q[c] <= $signed(48'({1'b0, wt_wb_q})) * 48'(wt_pair_q.b[c]);
      end

      for (int c = 0; c < 4; c++)
        bs_r_q[c] <= bp_pa_q[c] + bp_pb_q[c];

      for (int c = 0; c < 4; c++) begin
        ab_r_q[c]  <= bs_r_q[c];
        ab_am_q[c] <= bs_r_q[c][47] ? 47'(-bs_r_q[c]) : bs_r_q[c][46:0];
      end

      m01 = (ab_am_q[0] > ab_am_q[1]) ? ab_am_q[0] : ab_am_q[1];
      m23 = (ab_am_q[2] > ab_am_q[3]) ? ab_am_q[2] : ab_am_q[3];
      mx_m_q <= (m01 > m23) ? m01 : m23;
      mx_r_q <= ab_r_q;

      top = mx_m_q[46:30];
      sh  = '0;
      for (int i = 0; i < 17; i++)
        if (top[i]) sh = 5'(i + 1);
      sh_sh_q   <= sh;
      sh_zero_q <= (mx_m_q == '0);
      sh_r_q    <= mx_r_q;

      for (int c = 0; c < 4; c++) begin
        r = sh_r_q[c] >>> sh_sh_q;
        rs_r_q[c] <= r[30:0];
      end
      rs_zero_q <= sh_zero_q;

      for (int c = 0; c < 4; c++) begin
        sq_sq_q[c]  <= $unsigned(62'(rs_r_q[c]) * 62'(rs_r_q[c]));
        sq_am_q[c]  <= rs_r_q[c][30] ? 31'(-rs_r_q[c]) : rs_r_q[c];
        sq_neg_q[c] <= rs_r_q[c][30];
      end
      sq_zero_q <= rs_zero_q;

      sum = 64'(sq_sq_q[0]) + 64'(sq_sq_q[1]) + 64'(sq_sq_q[2]) + 64'(sq_sq_q[3]);
      ss_sum_q       <= sum;
      ss_side.am     <= sq_am_q;
      ss_side.neg    <= sq_neg_q;
      ss_zero_q      <= sq_zero_q;
    end
  end

  qslerp_sqrt #(
    .InW   (64),
    .SideW ($bits(nrm_side_t))
  ) u_sqrt_norm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (ss_vld_q),
    .rad_i  (ss_sum_q),
    .side_i ({ss_side.am, ss_side.neg, ss_zero_q}),
    .vld_o  (sq2_vld),
    .root_o (sq2_root),
    .side_o (sq2_side)
  );

  // rounded numerators for the final scaling
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int c = 0; c < 4; c++)
        nd_num_q[c] <= (45'(sq2_side.am[c]) << CompFracBits) + 45'(sq2_root >> 1);
      nd_den_q       <= sq2_root;
      nd_side_q.neg  <= sq2_side.neg;
      nd_side_q.zero <= sq2_side.zero;
    end
  end

  qslerp_div #(
    .NumW  (45),
    .DenW  (32),
    .QuoW  (15),
    .Lanes (4),
    .SideW ($bits(out_side_t))
  ) u_div_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (nd_vld_q),
    .num_i  (nd_num_q),
    .den_i  (nd_den_q),
    .side_i (nd_side_q),
    .vld_o  (od_vld),
    .quo_o  (od_quo),
    .ovf_o  (od_ovf),
    .side_o (od_side)
  );

  // saturate, restore sign, substitute identity for a zero blend
  always_ff @(posedge clk_i) begin : p_out
    logic [14:0] q;
    if (adv) begin
      for (int c = 0; c < 4; c++) begin
        q = (od_ovf[c] || od_quo[c] > OneFrac) ? OneFrac : od_quo[c];
        if (od_side.zero) out_q[c] <= (c == 0) ? $signed(16'(OneFrac)) : '0;
        else if (od_side.neg[c]) out_q[c] <= -$signed(16'(q));
        else out_q[c] <= $signed(16'(q));
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_q[3], out_q[2], out_q[1], out_q[0]};

  `QSC_ASSERT_IMPLIES(a_sin_bound, clk_i, rst_ni, sq1_vld, sq1_root <= One30)
  `QSC_ASSERT_IMPLIES(a_norm_nonzero, clk_i, rst_ni, sq2_vld && !sq2_side.zero, sq2_root != '0)
  `QSC_ASSERT_IMPLIES(a_out_w_range, clk_i, rst_ni, m_axis_tvalid, out_q[0] <= 16'sd16384 && out_q[0] >= -16'sd16384)
  `QSC_ASSERT_NEXT(a_hold_stall, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && !s_axis_tready == !m_axis_tready)

endmodule
